>>> design/shlex_pkg.sv
// Shared types for the shell command lexer: beat layouts, lexer state and token codes.
package shlex_pkg;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_DQ     = 2'd1,
    MODE_SQ     = 2'd2
  } qmode_t;

  typedef enum logic [3:0] {
    H_NONE       = 4'd0,
    H_TWO        = 4'd1,
    H_TWO_GT     = 4'd2,
    H_TWO_GT_AMP = 4'd3,
    H_AMP        = 4'd4,
    H_AMP_GT     = 4'd5,
    H_LT         = 4'd6,
    H_LT_LT      = 4'd7,
    H_GT         = 4'd8,
    H_BSL        = 4'd9,
    H_DQ_BSL     = 4'd10
  } held_t;

  typedef enum logic [1:0] {
    RK_CHAR     = 2'd0,
    RK_WORD_END = 2'd1,
    RK_TOKEN    = 2'd2
  } rk_t;

  typedef enum logic [3:0] {
    TOK_NEWLINE       = 4'd0,
    TOK_ERR_APPEND    = 4'd1,
    TOK_ERR_TO_OUT    = 4'd2,
    TOK_ERR           = 4'd3,
    TOK_BOTH_APPEND   = 4'd4,
    TOK_BOTH          = 4'd5,
    TOK_BACKGROUND    = 4'd6,
    TOK_HERESTRING    = 4'd7,
    TOK_HEREDOC_STRIP = 4'd8,
    TOK_HEREDOC       = 4'd9,
    TOK_IN            = 4'd10,
    TOK_OUT_APPEND    = 4'd11,
    TOK_OUT           = 4'd12,
    TOK_PIPE          = 4'd13,
    TOK_SEMICOLON     = 4'd14,
    TOK_END           = 4'd15
  } tok_t;

  localparam int MAX_RES = 4;

  typedef struct packed {
    logic       kind;
    logic [7:0] byte_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0] result_kind;
    logic [3:0] token_code;
    logic [7:0] char_value;
    logic       last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [2:0]                cnt;
    out_item_t [MAX_RES-1:0]   res;
  } lex_bundle_t;

  typedef struct packed {
    qmode_t quote_mode;
    logic   word_open;
    held_t  held_prefix;
  } lex_state_t;

  typedef struct packed {
    logic full;
    logic avail;
  } qstat_t;

endpackage

>>> design/shlex_front.sv
// Front end: accepts input beats, runs the lexer state and packs each beat's results.
module shlex_front
  import shlex_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  input  qstat_t      qst,
  output logic        push,
  output lex_bundle_t push_data
);

  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SP     = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_ONE    = 8'h31;
  localparam logic [7:0] CH_TWO    = 8'h32;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_BSL    = 8'h5C;
  localparam logic [7:0] CH_BTICK  = 8'h60;
  localparam logic [7:0] CH_PIPE   = 8'h7C;

  localparam lex_state_t STATE_RESET = '{quote_mode: MODE_NORMAL, word_open: 1'b0,
                                         held_prefix: H_NONE};

  typedef struct packed {
    lex_state_t  st;
    lex_bundle_t b;
  } lex_out_t;

  function automatic lex_out_t add_res(lex_out_t x, rk_t k, tok_t code, logic [7:0] ch);
    lex_out_t y;
    y = x;
    if (y.b.cnt < 3'(MAX_RES)) begin
      y.b.res[y.b.cnt[1:0]] = '{result_kind: k, token_code: code, char_value: ch,
                                last_of_run: 1'b0};
      y.b.cnt = y.b.cnt + 3'd1;
    end
    return y;
  endfunction

  function automatic lex_out_t wchar(lex_out_t x, logic [7:0] ch);
    lex_out_t y;
    y = add_res(x, RK_CHAR, TOK_NEWLINE, ch);
    y.st.word_open = 1'b1;
    return y;
  endfunction

  function automatic lex_out_t close_w(lex_out_t x);
    lex_out_t y;
    y = x;
    if (y.st.word_open) begin
      y = add_res(y, RK_WORD_END, TOK_NEWLINE, 8'h00);
      y.st.word_open = 1'b0;
    end
    return y;
  endfunction

  function automatic lex_out_t tok(lex_out_t x, tok_t code);
    return add_res(x, RK_TOKEN, code, 8'h00);
  endfunction

  function automatic lex_out_t fresh_normal(lex_out_t x, logic [7:0] c);
    lex_out_t y;
    y = x;
    unique case (c)
      CH_SP, CH_TAB, CH_VT, CH_FF, CH_CR: y = close_w(y);
      CH_NL: begin
        y = close_w(y);
        y = tok(y, TOK_NEWLINE);
      end
      CH_DQUOTE: begin
        y = close_w(y);
        y.st.quote_mode = MODE_DQ;
      end
      CH_SQUOTE: begin
        y = close_w(y);
        y.st.quote_mode = MODE_SQ;
      end
      CH_BSL: y.st.held_prefix = H_BSL;
      CH_TWO: y.st.held_prefix = H_TWO;
      CH_AMP: begin
        y = close_w(y);
        y.st.held_prefix = H_AMP;
      end
      CH_LT: begin
        y = close_w(y);
        y.st.held_prefix = H_LT;
      end
      CH_GT: begin
        y = close_w(y);
        y.st.held_prefix = H_GT;
      end
      CH_PIPE: begin
        y = close_w(y);
        y = tok(y, TOK_PIPE);
      end
      CH_SEMI: begin
        y = close_w(y);
        y = tok(y, TOK_SEMICOLON);
      end
      default: y = wchar(y, c);
    endcase
    return y;
  endfunction

  function automatic lex_out_t lex_feed(lex_state_t s, logic [7:0] c);
    lex_out_t x;
    held_t    h;
    logic     done;
    x.st = s;
    x.b  = '0;
    done = 1'b0;
    // resolve at most two held prefixes, then one fresh pass
    for (int p = 0; p < 3; p++) begin
      if (!done) begin
        h = x.st.held_prefix;
        if (h == H_NONE) begin
          done = 1'b1;
          unique case (x.st.quote_mode)
            MODE_DQ: begin
              if (c == CH_DQUOTE) x.st.quote_mode = MODE_NORMAL;
              else if (c == CH_BSL) x.st.held_prefix = H_DQ_BSL;
              else x = wchar(x, c);
            end
            MODE_SQ: begin
              if (c == CH_SQUOTE) x.st.quote_mode = MODE_NORMAL;
              else x = wchar(x, c);
            end
            default: x = fresh_normal(x, c);
          endcase
        end else begin
          x.st.held_prefix = H_NONE;
          unique case (h)
            H_TWO: begin
              if (c == CH_GT) begin
                x = close_w(x);
                x.st.held_prefix = H_TWO_GT;
                done = 1'b1;
              end else begin
                x = wchar(x, CH_TWO);
              end
            end
            H_TWO_GT: begin
              if (c == CH_GT) begin
                x = tok(x, TOK_ERR_APPEND);
                done = 1'b1;
              end else if (c == CH_AMP) begin
                x.st.held_prefix = H_TWO_GT_AMP;
                done = 1'b1;
              end else begin
                x = tok(x, TOK_ERR);
              end
            end
            H_TWO_GT_AMP: begin
              if (c == CH_ONE) begin
                x = tok(x, TOK_ERR_TO_OUT);
                done = 1'b1;
              end else begin
                x = tok(x, TOK_ERR);
                x.st.held_prefix = H_AMP;
              end
            end
            H_AMP: begin
              if (c == CH_GT) begin
                x.st.held_prefix = H_AMP_GT;
                done = 1'b1;
              end else begin
                x = tok(x, TOK_BACKGROUND);
              end
            end
            H_AMP_GT: begin
              if (c == CH_GT) begin
                x = tok(x, TOK_BOTH_APPEND);
                done = 1'b1;
              end else begin
                x = tok(x, TOK_BOTH);
              end
            end
            H_LT: begin
              if (c == CH_LT) begin
                x.st.held_prefix = H_LT_LT;
                done = 1'b1;
              end else begin
                x = tok(x, TOK_IN);
              end
            end
            H_LT_LT: begin
              if (c == CH_LT) begin
                x = tok(x, TOK_HERESTRING);
                done = 1'b1;
              end else if (c == CH_DASH) begin
                x = tok(x, TOK_HEREDOC_STRIP);
                done = 1'b1;
              end else begin
                x = tok(x, TOK_HEREDOC);
              end
            end
            H_GT: begin
              if (c == CH_GT) begin
                x = tok(x, TOK_OUT_APPEND);
                done = 1'b1;
              end else begin
                x = tok(x, TOK_OUT);
              end
            end
            H_BSL: begin
              x = wchar(x, c);
              done = 1'b1;
            end
            H_DQ_BSL: begin
              if (c == CH_DQUOTE || c == CH_BSL || c == CH_DOLLAR || c == CH_BTICK) begin
                x = wchar(x, c);
                done = 1'b1;
              end else begin
                x = wchar(x, CH_BSL);
              end
            end
            default: done = 1'b1;
          endcase
        end
      end
    end
    return x;
  endfunction

  function automatic lex_out_t lex_finish(lex_state_t s);
    lex_out_t x;
    x.st = s;
    x.b  = '0;
    unique case (s.held_prefix)
      H_TWO:        x = wchar(x, CH_TWO);
      H_TWO_GT:     x = tok(x, TOK_ERR);
      H_TWO_GT_AMP: begin
        x = tok(x, TOK_ERR);
        x = tok(x, TOK_BACKGROUND);
      end
      H_AMP:        x = tok(x, TOK_BACKGROUND);
      H_AMP_GT:     x = tok(x, TOK_BOTH);
      H_LT:         x = tok(x, TOK_IN);
      H_LT_LT:      x = tok(x, TOK_HEREDOC);
      H_GT:         x = tok(x, TOK_OUT);
      H_DQ_BSL:     x = wchar(x, CH_BSL);
      default:      x = x;
    endcase
    x = close_w(x);
    x = tok(x, TOK_END);
    x.st = STATE_RESET;
    return x;
  endfunction

  lex_state_t state_r;
  lex_state_t state_nxt;
  lex_out_t   step;
  logic       accept;

  always_comb begin
    if (in_data.kind) begin
      step = lex_finish(state_r);
    end else begin
      step = lex_feed(state_r, in_data.byte_value);
    end
  end

  assign state_nxt = step.st;
  assign in_ready  = !qst.full;
  assign accept    = in_valid && in_ready;
  assign push      = accept && (step.b.cnt != 3'd0);
  assign push_data = step.b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= STATE_RESET;
    end else if (accept) begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> design/shlex_queue.sv
// Result-bundle queue between the lexer front end and the output serializer.
module shlex_queue
  import shlex_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  lex_bundle_t push_data,
  input  logic        pop,
  output lex_bundle_t head,
  output qstat_t      qst
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  lex_bundle_t     mem [DEPTH];
  logic [AW-1:0]   wr_ptr_r;
  logic [AW-1:0]   rd_ptr_r;
  logic [CW-1:0]   cnt_r;
  logic [AW-1:0]   wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_nxt;

  assign wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
  assign rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;

  assign head      = mem[rd_ptr_r];
  assign qst.full  = (cnt_r == CW'(DEPTH));
  assign qst.avail = (cnt_r != '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_nxt;
      if (pop)  rd_ptr_r <= rd_ptr_nxt;
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

>>> design/shlex_back.sv
// Back end: unpacks queued bundles into registered beats, one per cycle when not stalled.
module shlex_back
  import shlex_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  lex_bundle_t head,
  input  qstat_t      qst,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data
);

  logic [1:0] idx_r;
  logic       out_valid_r;
  out_item_t  out_data_r;
  logic       load;
  logic       is_last;
  out_item_t  cur;

  assign load    = qst.avail && (!out_valid_r || out_ready);
  assign is_last = ({1'b0, idx_r} == (head.cnt - 3'd1));
  assign pop     = load && is_last;

  always_comb begin
    cur = head.res[idx_r];
    cur.last_of_run = is_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
      idx_r       <= is_last ? 2'd0 : idx_r + 2'd1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= cur;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> design/shell_command_lexer_core.sv
// Top level of the shell command lexer: front end, bundle queue and output serializer.
//
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_ready  | in_data   (in_item_t)
//  out     | output    | out_valid / out_ready| out_data  (out_item_t)
//
// One input beat is taken per cycle while the queue has room; its results (up to four)
// are formed in that cycle and queued as one bundle.
// The serializer sends one result beat per cycle while the output is not stalled: each result
// of a beat becomes its own output beat, and a beat with none costs nothing downstream.
// Reset is synchronous, active low, and returns the lexer to normal mode with nothing held.
// An output stall holds the output register; the queue absorbs QUEUE_DEPTH bundles first.
module shell_command_lexer_core
  import shlex_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  qstat_t      qst;
  logic        push;
  logic        pop;
  lex_bundle_t push_data;
  lex_bundle_t head;

  shlex_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .qst       (qst),
    .push      (push),
    .push_data (push_data)
  );

  shlex_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .qst       (qst)
  );

  shlex_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .qst       (qst),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> design/shlex_checker.sv
// Port-level checks for the shell command lexer and their binding to the top level.
module shlex_checker
  import shlex_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output beat changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.result_kind != RK_CHAR) |-> out_data.char_value == 8'h00)
    else $error("char_value set on non-character beat");

  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.result_kind == RK_TOKEN) && (out_data.token_code == TOK_END)
      |-> out_data.last_of_run)
    else $error("end-of-input beat not marked last");

  a_end_in_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.kind && out_valid && !out_ready
      |=> out_valid)
    else $error("pending output dropped");

endmodule

bind shell_command_lexer_core shlex_checker u_shlex_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
